[hw/rtl/mpbg_pkg.sv]
// mpbg_pkg: shared types and constants for the pulse burst generator
// channel record layout, opcodes, sequencer states and size constants
// no dependencies
package mpbg_pkg;

    localparam int CHANNELS_DEF  = 8;
    localparam int CH_W          = 6;
    localparam int MAX_RESULTS   = 8;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam logic [7:0] ENDLESS_COUNT = 8'hFF;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_LOAD   = 2'd1,
        OP_ENABLE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_WALK,
        ST_FLUSH
    } seq_state_t;

    typedef struct packed {
        logic        enable;
        logic [7:0]  pulses_left;
        logic [31:0] interval;
        logic [15:0] high_length;
        logic [15:0] period_last;
        logic [15:0] phase;
        logic        level;
        logic [31:0] last_time;
    } chan_entry_t;

endpackage

[hw/rtl/multichannel_pulse_burst_generator.sv]
// multichannel_pulse_burst_generator: table of pulse channels in one memory,
// walked once per tick item; load and enable items update one record
// depends on mpbg_pkg
//
// channel   direction  handshake              payload
// input     in         in_valid / in_stall    opcode, channel, now_time, pulse_count,
//                                             step_interval, high_length, period_last,
//                                             start_phase, start_level, enable_value
// result    out        out_valid / out_stall  out_channel, out_level, last
//
// a load or enable item reads its record when accepted, then writes it back in ST_MODIFY
// a tick item walks every channel, then flushes any held result: one channel
// record is read per cycle from the single memory read port unless a stall holds
// the walk; the registered record is evaluated and written back during the next channel's read
// one result is held back until the walk knows whether it is the last one
// reset clears all control state and the per-entry valid bits at once; an
// entry never written reads as all zero, so no clearing pass is needed
// a stalled output only holds the walk when a second result must be handed on
module multichannel_pulse_burst_generator
    import mpbg_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [5:0]  channel,
    input  logic [31:0] now_time,
    input  logic [7:0]  pulse_count,
    input  logic [31:0] step_interval,
    input  logic [15:0] high_length,
    input  logic [15:0] period_last,
    input  logic [15:0] start_phase,
    input  logic        start_level,
    input  logic        enable_value,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  out_channel,
    output logic        out_level,
    output logic        last
);

    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W = $clog2(CHANNELS + 1);

    // sequencer and walk control
    seq_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [AW-1:0]      ev_idx_reg, ev_idx_next;
    logic               ev_vld_reg, ev_vld_next;
    logic [CNT_W-1:0]   n_reg, n_next;

    // latched command
    logic [1:0]         cmd_op_reg;
    logic [AW-1:0]      cmd_ch_reg;
    logic [31:0]        now_reg;
    logic [7:0]         ld_pulses_reg;
    logic [31:0]        ld_interval_reg;
    logic [15:0]        ld_high_reg;
    logic [15:0]        ld_period_reg;
    logic [15:0]        ld_phase_reg;
    logic               ld_level_reg;
    logic               en_value_reg;

    // held result and output register
    logic               pend_vld_reg, pend_vld_next;
    logic [AW-1:0]      pend_ch_reg, pend_ch_next;
    logic               pend_level_reg, pend_level_next;
    logic               out_vld_reg, out_vld_next;
    logic [AW-1:0]      out_ch_reg;
    logic               out_level_reg;
    logic               out_last_reg;

    // channel memory
    chan_entry_t        chan_mem [CHANNELS];
    logic [CHANNELS-1:0] wr_seen_reg;
    chan_entry_t        rd_data_reg;
    logic               rd_seen_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    chan_entry_t        wr_data;

    // datapath
    logic               accept;
    logic               in_range;
    logic               out_free;
    chan_entry_t        ev;
    logic [31:0]        elapsed;
    logic               due;
    logic               step;
    logic               hold;
    logic               advance;
    logic               walk_end;
    logic               new_level;
    logic [15:0]        phase_inc;
    logic               wrap;
    chan_entry_t        stepped;
    chan_entry_t        modified;
    logic               push;
    logic               push_last;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign in_range  = ({1'b0, channel} < 7'(CHANNELS));
    assign out_free  = !out_vld_reg || !out_stall;

    assign out_valid   = out_vld_reg;
    assign out_channel = 6'(out_ch_reg);
    assign out_level   = out_level_reg;
    assign last        = out_last_reg;

    // entry under evaluation, zero when never written
    assign ev = rd_seen_reg ? rd_data_reg : '0;

    // step decision for the entry in the read register
    assign elapsed   = now_reg - ev.last_time;
    assign due       = (elapsed >= ev.interval);
    assign step      = (state_reg == ST_WALK) && ev_vld_reg && ev.enable
                       && (ev.pulses_left != 8'd0) && due
                       && (n_reg < CNT_W'(MAX_RESULTS));
    assign hold      = step && pend_vld_reg && !out_free;
    assign advance   = (state_reg == ST_WALK) && !hold;
    assign walk_end  = advance && (idx_reg == IDX_W'(CHANNELS));

    assign new_level = (ev.phase <= ev.high_length);
    assign phase_inc = ev.phase + 16'd1;
    assign wrap      = (phase_inc > ev.period_last);

    always_comb
    begin
        stepped           = ev;
        stepped.last_time = now_reg;
        stepped.level     = new_level;
        stepped.phase     = wrap ? 16'd0 : phase_inc;
        if (wrap && (ev.pulses_left != ENDLESS_COUNT))
        begin
            stepped.pulses_left = ev.pulses_left - 8'd1;
        end
    end

    // read-modify-write merge for load and enable items
    always_comb
    begin
        modified = ev;
        if (cmd_op_reg == OP_LOAD)
        begin
            modified.pulses_left = ld_pulses_reg;
            modified.interval    = ld_interval_reg;
            modified.high_length = ld_high_reg;
            modified.period_last = ld_period_reg;
            modified.phase       = ld_phase_reg;
            modified.level       = ld_level_reg;
        end
        else
        begin
            modified.enable = en_value_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_TICK)
                    begin
                        state_next = ST_WALK;
                    end
                    else if ((opcode == OP_LOAD || opcode == OP_ENABLE) && in_range)
                    begin
                        state_next = ST_MODIFY;
                    end
                end
            end
            ST_MODIFY:
            begin
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_vld_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory port control, walk counters and result hand-off
    always_comb
    begin
        rd_en           = 1'b0;
        rd_addr         = idx_reg[AW-1:0];
        mem_we          = 1'b0;
        wr_addr         = ev_idx_reg;
        wr_data         = stepped;
        idx_next        = idx_reg;
        ev_idx_next     = ev_idx_reg;
        ev_vld_next     = ev_vld_reg;
        n_next          = n_reg;
        pend_vld_next   = pend_vld_reg;
        pend_ch_next    = pend_ch_reg;
        pend_level_next = pend_level_reg;
        push            = 1'b0;
        push_last       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // read the addressed record straight away for a load or enable
                rd_en       = accept;
                rd_addr     = channel[AW-1:0];
                idx_next    = '0;
                ev_vld_next = 1'b0;
                n_next      = '0;
            end
            ST_MODIFY:
            begin
                mem_we  = 1'b1;
                wr_addr = cmd_ch_reg;
                wr_data = modified;
            end
            ST_WALK:
            begin
                if (advance)
                begin
                    rd_en       = (idx_reg != IDX_W'(CHANNELS));
                    ev_vld_next = rd_en;
                    ev_idx_next = idx_reg[AW-1:0];
                    if (rd_en)
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                    if (step)
                    begin
                        mem_we          = 1'b1;
                        n_next          = n_reg + CNT_W'(1);
                        push            = pend_vld_reg;
                        pend_vld_next   = 1'b1;
                        pend_ch_next    = ev_idx_reg;
                        pend_level_next = new_level;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_vld_reg && out_free)
                begin
                    push          = 1'b1;
                    push_last     = 1'b1;
                    pend_vld_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        out_vld_next = push ? 1'b1 : (out_vld_reg && out_stall);
    end

    // channel memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            chan_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= chan_mem[rd_addr];
        end
    end

    // written-entry flags, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_seen_reg <= '0;
            rd_seen_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                wr_seen_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_seen_reg <= wr_seen_reg[rd_addr];
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            ev_vld_reg   <= 1'b0;
            n_reg        <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            ev_vld_reg   <= ev_vld_next;
            n_reg        <= n_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ev_idx_reg     <= ev_idx_next;
        pend_ch_reg    <= pend_ch_next;
        pend_level_reg <= pend_level_next;
        if (accept)
        begin
            cmd_op_reg      <= opcode;
            cmd_ch_reg      <= channel[AW-1:0];
            now_reg         <= now_time;
            ld_pulses_reg   <= pulse_count;
            ld_interval_reg <= step_interval;
            ld_high_reg     <= high_length;
            ld_period_reg   <= period_last;
            ld_phase_reg    <= start_phase;
            ld_level_reg    <= start_level;
            en_value_reg    <= enable_value;
        end
        if (push)
        begin
            out_ch_reg    <= pend_ch_reg;
            out_level_reg <= pend_level_reg;
            out_last_reg  <= push_last;
        end
    end

    // checks
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_vld_reg)
        else $error("result still held while idle");

    a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(MAX_RESULTS))
        else $error("result count beyond limit");

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write of the same channel record in one cycle");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result handed on while output register still stalled");

    a_eval_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ev_vld_reg |-> (state_reg == ST_WALK))
        else $error("record under evaluation outside a walk");

endmodule

[test/multichannel_pulse_burst_generator_tb.sv]
`timescale 1ns / 100ps
// multichannel_pulse_burst_generator_tb: self-checking bench for the pulse burst generator
// feeds load, enable and tick transfers and checks each result against a channel table of its own
// depends on mpbg_pkg and multichannel_pulse_burst_generator
module multichannel_pulse_burst_generator_tb;
    import mpbg_pkg::*;

    localparam int NCH          = CHANNELS_DEF;
    localparam int TARGET_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = NCH + 16;
    // the one opcode the block has no use for
    localparam logic [1:0] OP_SPARE = 2'd3;

    // one input transfer, every payload field carried whatever the opcode
    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  chan;
        logic [31:0] now;
        logic [7:0]  count;
        logic [31:0] interval;
        logic [15:0] high;
        logic [15:0] period;
        logic [15:0] phase;
        logic        level;
        logic        enable;
    } burst_cmd_t;

    // one channel step as the result side shows it
    typedef struct packed {
        logic [5:0] chan;
        logic       level;
        logic       last;
    } pulse_step_t;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_RUNS
    } stall_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [5:0]  channel;
    logic [31:0] now_time;
    logic [7:0]  pulse_count;
    logic [31:0] step_interval;
    logic [15:0] high_length;
    logic [15:0] period_last;
    logic [15:0] start_phase;
    logic        start_level;
    logic        enable_value;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  out_channel;
    logic        out_level;
    logic        last;

    // transfer currently offered to the block; the ports follow it
    burst_cmd_t cur_cmd = '0;
    logic       in_taken = 1'b0;

    burst_cmd_t  cmd_backlog[$];
    pulse_step_t expected_steps[$];

    // channel table kept alongside the block, reset state all zero
    logic        tbl_enable   [NCH];
    logic [7:0]  tbl_left     [NCH];
    logic [31:0] tbl_interval [NCH];
    logic [15:0] tbl_high     [NCH];
    logic [15:0] tbl_period   [NCH];
    logic [15:0] tbl_phase    [NCH];
    logic        tbl_level    [NCH];
    logic [31:0] tbl_stamp    [NCH];

    int queued_cmds    = 0;
    int useful_items   = 0;
    int accepted_cmds  = 0;
    int accepted_ticks = 0;
    int steps_checked  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // sender pacing
    int burst_left = 0;
    int gap_left   = 0;

    // receiver pacing
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_mode_left = 0;
    int          stall_run = 0;
    logic        stall_on = 1'b0;

    assign opcode        = cur_cmd.op;
    assign channel       = cur_cmd.chan;
    assign now_time      = cur_cmd.now;
    assign pulse_count   = cur_cmd.count;
    assign step_interval = cur_cmd.interval;
    assign high_length   = cur_cmd.high;
    assign period_last   = cur_cmd.period;
    assign start_phase   = cur_cmd.phase;
    assign start_level   = cur_cmd.level;
    assign enable_value  = cur_cmd.enable;

    multichannel_pulse_burst_generator #(
        .CHANNELS(NCH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .channel      (channel),
        .now_time     (now_time),
        .pulse_count  (pulse_count),
        .step_interval(step_interval),
        .high_length  (high_length),
        .period_last  (period_last),
        .start_phase  (start_phase),
        .start_level  (start_level),
        .enable_value (enable_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_channel  (out_channel),
        .out_level    (out_level),
        .last         (last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // channel table update; a tick queues the steps it should produce
    // ------------------------------------------------------------------
    task automatic apply_burst_cmd(input burst_cmd_t c);
        int          n;
        logic [15:0] next_phase;
        pulse_step_t held;
        logic        have_held;
        n = 0;
        have_held = 1'b0;
        held = '0;
        if (c.op == OP_LOAD) begin
            // out-of-range channels fall through untouched
            if (c.chan < NCH) begin
                tbl_left[c.chan]     = c.count;
                tbl_interval[c.chan] = c.interval;
                tbl_high[c.chan]     = c.high;
                tbl_period[c.chan]   = c.period;
                tbl_phase[c.chan]    = c.phase;
                tbl_level[c.chan]    = c.level;
            end
        end else if (c.op == OP_ENABLE) begin
            if (c.chan < NCH)
                tbl_enable[c.chan] = c.enable;
        end else if (c.op == OP_TICK) begin
            for (int i = 0; i < NCH; i++) begin
                // elapsed time is a modular 32-bit difference
                if (n < MAX_RESULTS && tbl_enable[i] && tbl_left[i] != 8'd0
                        && (c.now - tbl_stamp[i]) >= tbl_interval[i]) begin
                    tbl_stamp[i] = c.now;
                    tbl_level[i] = (tbl_phase[i] <= tbl_high[i]);
                    next_phase = tbl_phase[i] + 16'd1;
                    // a phase that wraps to zero never passes the period
                    if (next_phase > tbl_period[i]) begin
                        next_phase = 16'd0;
                        if (tbl_left[i] != ENDLESS_COUNT)
                            tbl_left[i] = tbl_left[i] - 8'd1;
                    end
                    tbl_phase[i] = next_phase;
                    // hold each step back until it is known whether another follows
                    if (have_held)
                        expected_steps.push_back(held);
                    held = '{chan: 6'(i), level: tbl_level[i], last: 1'b0};
                    have_held = 1'b1;
                    n++;
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                expected_steps.push_back(held);
            end
        end
    endtask

    task automatic note_mismatch(input string what, input pulse_step_t want,
                                 input pulse_step_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s at cycle %0d: expected ch %0d level %0b last %0b, got ch %0d level %0b last %0b",
                     what, cycle_count, want.chan, want.level, want.last,
                     got.chan, got.level, got.last);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers: every field starts random, then the ones that
    // matter are set, so the unused payload bits toggle too
    // ------------------------------------------------------------------
    function automatic burst_cmd_t noise_cmd();
        burst_cmd_t c;
        c.op       = 2'($urandom_range(0, 3));
        c.chan     = 6'($urandom);
        c.now      = $urandom;
        c.count    = 8'($urandom);
        c.interval = $urandom;
        c.high     = 16'($urandom);
        c.period   = 16'($urandom);
        c.phase    = 16'($urandom);
        c.level    = 1'($urandom);
        c.enable   = 1'($urandom);
        return c;
    endfunction

    task automatic push_cmd(input burst_cmd_t c);
        cmd_backlog.push_back(c);
        queued_cmds++;
        // ignored transfers do not count towards the stimulus total
        if (c.op == OP_TICK || (c.op != OP_SPARE && c.chan < NCH))
            useful_items++;
    endtask

    task automatic push_tick(input logic [31:0] t);
        burst_cmd_t c;
        c = noise_cmd();
        c.op = OP_TICK;
        c.now = t;
        push_cmd(c);
    endtask

    task automatic push_load(input logic [5:0] ch, input logic [7:0] cnt,
                             input logic [31:0] ivl, input logic [15:0] hi,
                             input logic [15:0] per, input logic [15:0] ph,
                             input logic lvl);
        burst_cmd_t c;
        c = noise_cmd();
        c.op       = OP_LOAD;
        c.chan     = ch;
        c.count    = cnt;
        c.interval = ivl;
        c.high     = hi;
        c.period   = per;
        c.phase    = ph;
        c.level    = lvl;
        push_cmd(c);
    endtask

    task automatic push_enable(input logic [5:0] ch, input logic en);
        burst_cmd_t c;
        c = noise_cmd();
        c.op     = OP_ENABLE;
        c.chan   = ch;
        c.enable = en;
        push_cmd(c);
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of transfers with random gaps, payload held while stalled
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left--;
                end else if (cmd_backlog.size() > 0) begin
                    cur_cmd  <= cmd_backlog.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else begin
                        burst_left = $urandom_range(1, 24);
                        // some bursts run straight on with no gap
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: switches between no stall, scattered stall and stall runs
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      = stall_mode_t'($urandom_range(0, 2));
            stall_mode_left = $urandom_range(20, 120);
        end
        stall_mode_left--;
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                if (stall_run == 0) begin
                    stall_run = $urandom_range(1, 12);
                    stall_on  = ~stall_on;
                end
                stall_run--;
                out_stall <= stall_on;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // monitor: predict on each input transfer, then check each result
    // ------------------------------------------------------------------
    always @(posedge clk) begin : watch_ports
        pulse_step_t want;
        pulse_step_t got;
        if (rst_n) begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                apply_burst_cmd(cur_cmd);
                accepted_cmds++;
                if (cur_cmd.op == OP_TICK)
                    accepted_ticks++;
            end
            if (out_valid && !out_stall) begin
                got = '{chan: out_channel, level: out_level, last: last};
                steps_checked++;
                if (expected_steps.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    want = expected_steps.pop_front();
                    if (got.chan !== want.chan || got.level !== want.level
                            || got.last !== want.last)
                        note_mismatch("wrong result", want, got);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timed out with %0d transfers accepted, %0d steps outstanding",
                     accepted_cmds, expected_steps.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] clock_now;
        logic [5:0]  ch;
        logic [7:0]  cnt;
        logic [31:0] ivl;
        logic [15:0] hi;
        logic [15:0] per;
        logic [15:0] ph;

        for (int i = 0; i < NCH; i++) begin
            tbl_enable[i]   = 1'b0;
            tbl_left[i]     = '0;
            tbl_interval[i] = '0;
            tbl_high[i]     = '0;
            tbl_period[i]   = '0;
            tbl_phase[i]    = '0;
            tbl_level[i]    = 1'b0;
            tbl_stamp[i]    = '0;
        end

        // directed part
        push_tick(32'd0);                                    // nothing enabled yet
        push_load(6'd0, 8'd3, 32'd0, 16'd0, 16'd1, 16'd0, 1'b1);
        push_enable(6'd0, 1'b1);
        // top channel: endless count, widest interval, phase about to wrap
        push_load(6'(NCH - 1), ENDLESS_COUNT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF, 1'b0);
        push_enable(6'(NCH - 1), 1'b1);
        // channels past the table and the spare opcode are dropped
        push_load(6'(NCH), 8'd5, 32'd0, 16'd3, 16'd3, 16'd0, 1'b1);
        push_enable(6'd63, 1'b1);
        push_cmd('{op: OP_SPARE, chan: 6'd0, now: 32'd0, count: 8'hFF,
                   interval: 32'd0, high: 16'hFFFF, period: 16'hFFFF,
                   phase: 16'd0, level: 1'b1, enable: 1'b1});
        // enabled but no pulses left
        push_load(6'd3, 8'd0, 32'd0, 16'd5, 16'd5, 16'd0, 1'b0);
        push_enable(6'd3, 1'b1);
        push_tick(32'd0);
        push_tick(32'hFFFF_FFFF);                            // top channel finally due
        push_tick(32'd5);                                    // time wrapped past zero
        push_enable(6'd0, 1'b0);
        push_tick(32'd6);
        // phase above the period: low level, count taken at once
        push_load(6'd0, 8'd2, 32'd1, 16'd0, 16'd3, 16'd5, 1'b1);
        push_enable(6'd0, 1'b1);
        push_tick(32'd7);
        push_tick(32'd7);                                    // interval not yet elapsed
        push_tick(32'd8);
        push_tick(32'd9);

        // random part: mostly channel programs followed by runs of ticks
        clock_now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom;
        while (useful_items < TARGET_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(1, NCH)) begin
                    ch = 6'($urandom_range(0, NCH - 1));
                    case ($urandom_range(0, 5))
                        0:       cnt = 8'd0;
                        1:       cnt = ENDLESS_COUNT;
                        2:       cnt = 8'($urandom);
                        default: cnt = 8'($urandom_range(1, 4));
                    endcase
                    case ($urandom_range(0, 7))
                        0:       ivl = $urandom;
                        1:       ivl = 32'hFFFF_FFFF - $urandom_range(0, 3);
                        default: ivl = $urandom_range(0, 6);
                    endcase
                    hi  = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
                    per = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
                    ph  = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10));
                    push_load(ch, cnt, ivl, hi, per, ph, 1'($urandom));
                    if ($urandom_range(0, 3) != 0)
                        push_enable(ch, 1'b1);
                end
                repeat ($urandom_range(2, 10)) begin
                    // mostly small steps, now and then a big jump
                    clock_now = clock_now + (($urandom_range(0, 9) == 0) ? $urandom
                                                                        : $urandom_range(0, 5));
                    push_tick(clock_now);
                end
                if ($urandom_range(0, 2) == 0)
                    push_enable(6'($urandom_range(0, NCH - 1)), 1'b0);
            end else begin
                repeat ($urandom_range(1, 4))
                    push_cmd(noise_cmd());
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_cmds < queued_cmds)
            @(posedge clk);
        while (expected_steps.size() > 0)
            @(posedge clk);
        // a tick with no result may still be walking the table
        repeat (DRAIN_CYCLES) @(posedge clk);

        while (expected_steps.size() > 0)
            note_mismatch("missing result", expected_steps.pop_front(), '0);

        $display("%0d transfers sent, %0d of them ticks, over %0d cycles",
                 accepted_cmds, accepted_ticks, cycle_count);
        $display("%0d channel steps checked, %0d mismatches", steps_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
